[hdl/tpsa_pkg.sv]
package tpsa_pkg;

    localparam int unsigned SMALL_SLOTS_DEF = 8;
    localparam int unsigned LARGE_SLOTS_DEF = 8;
    localparam int unsigned SMALL_BYTES_DEF = 32;
    localparam int unsigned LARGE_BYTES_DEF = 64;

    localparam int unsigned OFF_W  = 10;
    localparam int unsigned MASK_W = 8;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_BAD_OFFSET = 2'd2
    } t_status;

    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_FREE   = 1'b1;
    localparam logic KIND_SMALL = 1'b0;
    localparam logic KIND_LARGE = 1'b1;

    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  grant;
    } t_result;

endpackage

[hdl/tpsa_alloc.sv]
module tpsa_alloc #(
    parameter int unsigned SMALL_SLOTS = tpsa_pkg::SMALL_SLOTS_DEF,
    parameter int unsigned LARGE_SLOTS = tpsa_pkg::LARGE_SLOTS_DEF,
    parameter int unsigned SMALL_BYTES = tpsa_pkg::SMALL_BYTES_DEF,
    parameter int unsigned LARGE_BYTES = tpsa_pkg::LARGE_BYTES_DEF
) (
    input  logic                   i_kind,
    input  logic [SMALL_SLOTS-1:0] i_small_used,
    input  logic [LARGE_SLOTS-1:0] i_large_used,
    output logic [SMALL_SLOTS-1:0] o_small_set,
    output logic [LARGE_SLOTS-1:0] o_large_set,
    output tpsa_pkg::t_result      o_result
);

    localparam logic [31:0] LargeBase = 32'(SMALL_SLOTS * SMALL_BYTES);

    function automatic logic [tpsa_pkg::OFF_W-1:0] small_off(input int unsigned idx);
        logic [31:0] v;
        v = 32'(idx * SMALL_BYTES);
        return v[tpsa_pkg::OFF_W-1:0];
    endfunction

    function automatic logic [tpsa_pkg::OFF_W-1:0] large_off(input int unsigned idx);
        logic [31:0] v;
        v = LargeBase + 32'(idx * LARGE_BYTES);
        return v[tpsa_pkg::OFF_W-1:0];
    endfunction

    logic [SMALL_SLOTS-1:0]     s_free, s_hot, p_free, p_hot;
    logic [LARGE_SLOTS-1:0]     l_free, l_hot;
    logic [tpsa_pkg::OFF_W-1:0] s_grant, l_grant, p_grant;

    always_comb begin
        s_free = ~i_small_used;
        l_free = ~i_large_used;
        p_free = s_free & (s_free >> 1);
        s_hot  = s_free & (~s_free + SMALL_SLOTS'(1));
        l_hot  = l_free & (~l_free + LARGE_SLOTS'(1));
        p_hot  = p_free & (~p_free + SMALL_SLOTS'(1));
    end

    always_comb begin
        s_grant = '0;
        p_grant = '0;
        for (int unsigned i = 0; i < SMALL_SLOTS; i++) begin
            s_grant = s_grant | ({tpsa_pkg::OFF_W{s_hot[i]}} & small_off(i));
            p_grant = p_grant | ({tpsa_pkg::OFF_W{p_hot[i]}} & small_off(i));
        end
        l_grant = '0;
        for (int unsigned j = 0; j < LARGE_SLOTS; j++) begin
            l_grant = l_grant | ({tpsa_pkg::OFF_W{l_hot[j]}} & large_off(j));
        end
    end

    always_comb begin
        o_small_set     = '0;
        o_large_set     = '0;
        o_result.status = tpsa_pkg::ST_OK;
        o_result.grant  = '0;
        if (i_kind == tpsa_pkg::KIND_SMALL) begin
            if (|s_free) begin
                o_small_set    = s_hot;
                o_result.grant = s_grant;
            end else if (|l_free) begin
                o_large_set    = l_hot;
                o_result.grant = l_grant;
            end else begin
                o_result.status = tpsa_pkg::ST_NO_SPACE;
            end
        end else begin
            if (|l_free) begin
                o_large_set    = l_hot;
                o_result.grant = l_grant;
            end else if (|p_free) begin
                o_small_set    = p_hot | (p_hot << 1);
                o_result.grant = p_grant;
            end else begin
                o_result.status = tpsa_pkg::ST_NO_SPACE;
            end
        end
    end

endmodule

[hdl/tpsa_free.sv]
module tpsa_free #(
    parameter int unsigned SMALL_SLOTS = tpsa_pkg::SMALL_SLOTS_DEF,
    parameter int unsigned LARGE_SLOTS = tpsa_pkg::LARGE_SLOTS_DEF,
    parameter int unsigned SMALL_BYTES = tpsa_pkg::SMALL_BYTES_DEF,
    parameter int unsigned LARGE_BYTES = tpsa_pkg::LARGE_BYTES_DEF
) (
    input  logic                       i_kind,
    input  logic [tpsa_pkg::OFF_W-1:0] i_offset,
    output logic [SMALL_SLOTS-1:0]     o_small_clr,
    output logic [LARGE_SLOTS-1:0]     o_large_clr,
    output tpsa_pkg::t_status          o_status
);

    localparam logic [31:0] LargeBase = 32'(SMALL_SLOTS * SMALL_BYTES);
    localparam logic [31:0] PoolEnd   = LargeBase + 32'(LARGE_SLOTS * LARGE_BYTES);

    logic [31:0]            off;
    logic [SMALL_SLOTS-1:0] s_hit;
    logic [LARGE_SLOTS-1:0] l_hit;

    always_comb begin
        off = 32'(i_offset);
        for (int unsigned i = 0; i < SMALL_SLOTS; i++) begin
            s_hit[i] = (off >= 32'(i * SMALL_BYTES)) && (off < 32'((i + 1) * SMALL_BYTES));
        end
        for (int unsigned j = 0; j < LARGE_SLOTS; j++) begin
            l_hit[j] = (off >= LargeBase + 32'(j * LARGE_BYTES))
                    && (off < LargeBase + 32'((j + 1) * LARGE_BYTES));
        end
        o_large_clr = l_hit;
        o_small_clr = s_hit;
        if (i_kind == tpsa_pkg::KIND_LARGE) begin
            o_small_clr = s_hit | (s_hit << 1);
        end
        o_status = (off >= PoolEnd) ? tpsa_pkg::ST_BAD_OFFSET : tpsa_pkg::ST_OK;
    end

endmodule

[hdl/two_pool_slot_allocator_top.sv]
// Two-pool slot allocator: small and large fixed slots tracked by used-bit masks.
// Input channel (i_in_valid / o_in_ready) carries one request word: action
// (allocate or free), kind (small or large) and the byte offset to free.
// Output channel (o_out_valid / i_out_ready) returns one word per request:
// status, granted offset and both used masks after the request.
// An accepted request is held in the input register, then the slot search and
// mask update land in the result register. Throughput is one word per cycle
// while the receiver is ready; the masks update in the same edge that loads
// the result, so the next request sees them at once.
// Reset clears both masks (all slots free) and empties both registers.
// When the receiver stalls, the result register holds and the input
// register holds one more word; o_in_ready drops once both are full.
module two_pool_slot_allocator_top #(
    parameter int unsigned SMALL_SLOTS = tpsa_pkg::SMALL_SLOTS_DEF,
    parameter int unsigned LARGE_SLOTS = tpsa_pkg::LARGE_SLOTS_DEF,
    parameter int unsigned SMALL_BYTES = tpsa_pkg::SMALL_BYTES_DEF,
    parameter int unsigned LARGE_BYTES = tpsa_pkg::LARGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic                        i_kind,
    input  logic [tpsa_pkg::OFF_W-1:0]  i_offset_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [tpsa_pkg::OFF_W-1:0]  o_offset_out,
    output logic [tpsa_pkg::MASK_W-1:0] o_small_used,
    output logic [tpsa_pkg::MASK_W-1:0] o_large_used
);

    logic                        r_in_valid;
    logic                        r_action;
    logic                        r_kind;
    logic [tpsa_pkg::OFF_W-1:0]  r_offset;

    logic [SMALL_SLOTS-1:0]      r_small_mask, n_small_mask;
    logic [LARGE_SLOTS-1:0]      r_large_mask, n_large_mask;

    logic                        r_out_valid;
    tpsa_pkg::t_result           r_result, n_result;
    logic [tpsa_pkg::MASK_W-1:0] r_small_out, r_large_out;

    logic [SMALL_SLOTS-1:0]      small_set, small_clr;
    logic [LARGE_SLOTS-1:0]      large_set, large_clr;
    tpsa_pkg::t_result           alloc_res;
    tpsa_pkg::t_status           free_status;
    logic                        advance;
    logic [63:0]                 small_wide, large_wide;

    tpsa_alloc #(
        .SMALL_SLOTS(SMALL_SLOTS), .LARGE_SLOTS(LARGE_SLOTS),
        .SMALL_BYTES(SMALL_BYTES), .LARGE_BYTES(LARGE_BYTES)
    ) u_alloc (
        .i_kind       (r_kind),
        .i_small_used (r_small_mask),
        .i_large_used (r_large_mask),
        .o_small_set  (small_set),
        .o_large_set  (large_set),
        .o_result     (alloc_res)
    );

    tpsa_free #(
        .SMALL_SLOTS(SMALL_SLOTS), .LARGE_SLOTS(LARGE_SLOTS),
        .SMALL_BYTES(SMALL_BYTES), .LARGE_BYTES(LARGE_BYTES)
    ) u_free (
        .i_kind      (r_kind),
        .i_offset    (r_offset),
        .o_small_clr (small_clr),
        .o_large_clr (large_clr),
        .o_status    (free_status)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        if (r_action == tpsa_pkg::ACT_ALLOC) begin
            n_small_mask = r_small_mask | small_set;
            n_large_mask = r_large_mask | large_set;
            n_result     = alloc_res;
        end else begin
            n_small_mask = r_small_mask & ~small_clr;
            n_large_mask = r_large_mask & ~large_clr;
            n_result.status = free_status;
            n_result.grant  = '0;
        end
        small_wide = 64'(n_small_mask);
        large_wide = 64'(n_large_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_small_mask <= '0;
            r_large_mask <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_small_mask <= n_small_mask;
                r_large_mask <= n_large_mask;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_kind   <= i_kind;
            r_offset <= i_offset_in;
        end
        if (advance) begin
            r_result    <= n_result;
            r_small_out <= small_wide[tpsa_pkg::MASK_W-1:0];
            r_large_out <= large_wide[tpsa_pkg::MASK_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_result.status;
    assign o_offset_out = r_result.grant;
    assign o_small_used = r_small_out;
    assign o_large_used = r_large_out;

endmodule
